// ----- rtl/msjf_pkg.sv -----
// ----------------------------------------------------------------------------
// msjf_pkg
// Types and constants shared by the multilevel SJF scheduler modules.
// ----------------------------------------------------------------------------
package msjf_pkg;

  localparam int unsigned LvlW = 4;

  typedef enum logic [1:0] {
    ST_ADMITTED   = 2'd0,
    ST_REFUSED    = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic {
    OP_ADMIT    = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CELL_NOP  = 2'd0,
    CELL_INS  = 2'd1,
    CELL_POP  = 2'd2,
    CELL_DROP = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic            valid;
    logic [LvlW-1:0] lvl;
    logic [7:0]      id;
    logic [15:0]     burst;
  } entry_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  proc_id;
    logic [1:0]  level;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  proc_id_res;
    logic [15:0] burst_res;
    logic [31:0] start_time;
  } out_item_t;

endpackage

// ----- rtl/msjf_cell.sv -----
// ----------------------------------------------------------------------------
// msjf_cell
// One slot of the ordered entry chain: insert, shift-out and tail drop.
// ----------------------------------------------------------------------------
module msjf_cell import msjf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_op_e cmd_i,
  input  entry_t   new_i,
  input  entry_t   left_i,
  input  entry_t   right_i,
  input  logic     first_i,
  input  logic     ge_i,
  output entry_t   entry_o,
  output logic     ge_o,
  output logic     last_o
);

  entry_t entry_q, entry_d;
  logic   head, pred;

  // head of the new entry's level segment
  assign head = first_i | !left_i.valid | (left_i.lvl != new_i.lvl);

  always_comb begin
    pred = 1'b0;
    if (!entry_q.valid || entry_q.lvl > new_i.lvl) begin
      pred = 1'b1;
    end else if (entry_q.lvl == new_i.lvl) begin
      pred = head ? (entry_q.burst >= new_i.burst) : (entry_q.burst > new_i.burst);
    end
  end

  assign ge_o    = pred | ge_i;
  assign last_o  = entry_q.valid & !right_i.valid;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i)
      CELL_INS: begin
        if (ge_o) begin
          entry_d = ge_i ? left_i : new_i;
        end
      end
      CELL_POP:  entry_d = right_i;
      CELL_DROP: begin
        if (last_o) begin
          entry_d.valid = 1'b0;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ----- rtl/multilevel_sjf_scheduler_with_aging_core.sv -----
// ----------------------------------------------------------------------------
// multilevel_sjf_scheduler_with_aging_core
// Multilevel shortest-job-first scheduler with aging over a chain of cells.
// ----------------------------------------------------------------------------
// Every input beat gives one registered result in the cycle after it is
// taken, and the next beat is taken only after that result has been
// delivered. A real dispatch with aging on also walks its aging crossings
// once the result is registered: each crossing takes a step (S_STEP) and a
// tail check (S_REM), plus a sorted insert (S_INS) when an entry is promoted,
// and a closing step ends the walk, with at most CAPACITY*LEVELS crossings
// walked. The time phase (time mod aging_interval) is kept between
// dispatches; after a write of aging_interval, or after a dispatch that had
// aging off, a zero burst or hit the crossing cap, the next aging dispatch
// first rebuilds it with a bit-serial remainder unit. Entries live in a row
// of CAPACITY cells that shift for an insert or a dispatch; a promotion
// drops the tail cell and re-inserts it with its level decremented.
module multilevel_sjf_scheduler_with_aging_core import msjf_pkg::*; #(
  parameter int unsigned LEVELS   = 4,
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AgeCap = CAPACITY * LEVELS;
  localparam int unsigned AgeW  = $clog2(AgeCap + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     t_q, t_d;
  logic [15:0]     iv_q, iv_d;
  logic [15:0]     ph_q, ph_d;
  logic            ph_ok_q, ph_ok_d;
  logic [15:0]     r_q, r_d;
  logic [AgeW-1:0] ages_q, ages_d;
  logic [31:0]     dv_q, dv_d;
  logic [4:0]      dcnt_q, dcnt_d;
  entry_t          ag_q, ag_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  cell_op_e        cmd;
  entry_t          new_e;
  entry_t          cells [CAPACITY];
  logic            ge    [CAPACITY];
  logic            lastv [CAPACITY];
  entry_t          tail;

  logic in_acc, out_acc, cfg_acc;
  logic [16:0] rem17;
  logic [15:0] d16;
  logic [32:0] dw, ev;

  assign out_acc     = out_valid_q & !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) | out_valid_q;
  assign in_acc      = in_valid_i & !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t lft, rgt;
    logic   gin;
    if (k == 0) begin : g_first
      assign lft = '0;
      assign gin = 1'b0;
    end else begin : g_mid
      assign lft = cells[k-1];
      assign gin = ge[k-1];
    end
    if (k == CAPACITY - 1) begin : g_end
      assign rgt = '0;
    end else begin : g_nxt
      assign rgt = cells[k+1];
    end
    msjf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .new_i   (new_e),
      .left_i  (lft),
      .right_i (rgt),
      .first_i (k == 0),
      .ge_i    (gin),
      .entry_o (cells[k]),
      .ge_o    (ge[k]),
      .last_o  (lastv[k])
    );
  end

  always_comb begin
    tail = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (lastv[k]) begin
        tail = cells[k];
      end
    end
  end

  assign rem17 = {ph_q, dv_q[31]};
  assign d16   = iv_q - ph_q;
  assign dw    = 33'h1_0000_0000 - {1'b0, t_q};
  assign ev    = (dw < {17'd0, d16}) ? dw : {17'd0, d16};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    iv_d        = iv_q;
    ph_d        = ph_q;
    ph_ok_d     = ph_ok_q;
    r_d         = r_q;
    ages_d      = ages_q;
    dv_d        = dv_q;
    dcnt_d      = dcnt_q;
    ag_d        = ag_q;
    out_valid_d = out_valid_q & !out_acc;
    out_d       = out_q;
    cmd         = CELL_NOP;
    new_e.valid = 1'b1;
    new_e.lvl   = LvlW'(in_data_i.level);
    new_e.id    = in_data_i.proc_id;
    new_e.burst = in_data_i.burst;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          iv_d    = cfg_data_i;
          ph_ok_d = 1'b0;
        end
        if (in_acc) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (in_data_i.op == OP_ADMIT) begin
            if (cnt_q == CntW'(CAPACITY) || 32'(in_data_i.level) >= LEVELS) begin
              out_d.status = ST_REFUSED;
            end else begin
              cmd          = CELL_INS;
              cnt_d        = cnt_q + 1'b1;
              out_d.status = ST_ADMITTED;
            end
          end else if (cnt_q == '0) begin
            out_d.status = ST_EMPTY;
          end else begin
            cmd               = CELL_POP;
            cnt_d             = cnt_q - 1'b1;
            out_d.status      = ST_DISPATCHED;
            out_d.proc_id_res = cells[0].id;
            out_d.burst_res   = cells[0].burst;
            out_d.start_time  = t_q;
            if (iv_q == '0 || cells[0].burst == '0) begin
              t_d     = t_q + 32'(cells[0].burst);
              ph_ok_d = 1'b0;
            end else begin
              r_d    = cells[0].burst;
              ages_d = '0;
              if (ph_ok_q) begin
                state_d = S_STEP;
              end else begin
                dv_d    = t_q;
                dcnt_d  = '0;
                ph_d    = '0;
                state_d = S_MOD;
              end
            end
          end
        end
      end
      S_MOD: begin
        // one remainder bit per cycle: phase = time mod interval
        ph_d   = (rem17 >= {1'b0, iv_q}) ? 16'(rem17 - {1'b0, iv_q}) : rem17[15:0];
        dv_d   = {dv_q[30:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 5'd31) begin
          ph_ok_d = 1'b1;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (ages_q == AgeW'(AgeCap)) begin
          t_d     = t_q + 32'(r_q);
          ph_ok_d = 1'b0;
          state_d = S_IDLE;
        end else if ({17'd0, r_q} >= ev) begin
          t_d     = t_q + ev[31:0];
          r_d     = r_q - ev[15:0];
          ph_d    = '0;
          ages_d  = ages_q + 1'b1;
          state_d = S_REM;
        end else begin
          t_d     = t_q + 32'(r_q);
          ph_d    = ph_q + r_q;
          state_d = S_IDLE;
        end
      end
      S_REM: begin
        if (tail.valid && tail.lvl != '0) begin
          cmd      = CELL_DROP;
          cnt_d    = cnt_q - 1'b1;
          ag_d     = tail;
          ag_d.lvl = tail.lvl - 1'b1;
          state_d  = S_INS;
        end else begin
          state_d = S_STEP;
        end
      end
      S_INS: begin
        cmd     = CELL_INS;
        new_e   = ag_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_STEP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      t_q         <= '0;
      iv_q        <= 16'd10;
      ph_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      t_q         <= t_d;
      iv_q        <= iv_d;
      ph_ok_q     <= ph_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q   <= ph_d;
    r_q    <= r_d;
    ages_q <= ages_d;
    dv_q   <= dv_d;
    dcnt_q <= dcnt_d;
    ag_q   <= ag_d;
    out_q  <= out_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY)) else $error("entry count above capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) == cells[0].valid) else $error("head cell disagrees with count");

  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == OP_DISPATCH && cnt_q != '0 |=>
      out_valid_q && out_q.status == ST_DISPATCHED)
    else $error("dispatch beat produced no dispatched result");

endmodule
